### rtl/encoder_angle_velocity_estimator_defines.svh
// Assertion macros shared by the encoder angle and velocity estimator RTL.
`ifndef ENCODER_ANGLE_VELOCITY_ESTIMATOR_DEFINES_SVH
`define ENCODER_ANGLE_VELOCITY_ESTIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication on aclk, switched off while aresetn is low.
`define EAVE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication on aclk, switched off while aresetn is low.
`define EAVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EAVE_ASSERT_NOW(lbl, ante, cons, msg)
`define EAVE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/eave_pkg.sv
// Types and constants for the encoder angle and velocity estimator.
package eave_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_POS,
        ST_MUL_VEL,
        ST_DIV,
        ST_DONE
    } eave_state_t;

    localparam int unsigned ANGLE_W   = 12;
    localparam int unsigned POS_W     = 19;
    localparam int unsigned VEL_W     = 32;
    localparam int unsigned FLAGS_W   = 3;
    localparam int unsigned ERR_W     = 32;
    localparam int unsigned TIME_W    = 64;
    localparam int unsigned ACC_W     = 64;
    localparam int unsigned QUO_W     = 38;
    localparam int unsigned DIFF_W    = 14;
    localparam int unsigned CNT_W     = 6;
    localparam int unsigned MUL_STEPS = 12;
    localparam int unsigned DIV_STEPS = 38;

    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 168;
    localparam int unsigned M_TUSER_W = 1;

    localparam int unsigned S_USER_STATUS_OK = 0;
    localparam int unsigned S_USER_ANGLE_OK  = 1;
    localparam int unsigned M_USER_VEL_VALID = 0;
    localparam int unsigned FLAG_LSB         = 3;

    // Pi in Q48, and pi in Q30 times one million (microseconds to seconds).
    localparam logic [ACC_W-1:0] PI_Q48     = 64'h0003243F6A8885A3;
    localparam logic [ACC_W-1:0] VEL_SCALE  = 64'd3373259426000000;
    localparam logic [ACC_W-1:0] POS_ROUND  = 64'h0000040000000000;
    localparam int unsigned      POS_SHIFT  = 43;
    localparam int unsigned      VEL_SHIFT  = 25;

    localparam logic [VEL_W-1:0] VEL_POS_MAX = 32'h7FFFFFFF;
    localparam logic [VEL_W-1:0] VEL_NEG_MAG = 32'h80000000;

endpackage

### rtl/encoder_angle_velocity_estimator.sv
// Encoder angle and velocity estimator: sensor samples in, one result per good angle read out.
// Each sample with a good angle read is accepted, then worked through 12 shift-add steps
// for the position, 12 for the scaled angle step and 38 restoring division steps, all on
// one shared 64-bit adder, and then loaded into the output register once that is free;
// s_tready stays low until then, so no new sample is taken before the last one is through.
// A sample whose angle read failed only bumps the error count.
// The result register lets a finished result wait for m_tready while the next sample
// is accepted and worked on.
`include "encoder_angle_velocity_estimator_defines.svh"

module encoder_angle_velocity_estimator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // status_byte, angle_high, angle_low, timestamp_us
    input  logic [eave_pkg::S_TDATA_W-1:0]  s_tdata,
    // status_read_ok, angle_read_ok
    input  logic [eave_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // angle_counts, position_q16, velocity_q16, magnet_flags, read_error_total,
    // sample_time_us, zero padding
    output logic [eave_pkg::M_TDATA_W-1:0]  m_tdata,
    // velocity_valid
    output logic [eave_pkg::M_TUSER_W-1:0]  m_tuser
);

    eave_pkg::eave_state_t state_reg, state_next;

    logic [eave_pkg::TIME_W-1:0]   prev_time_reg, prev_time_next;
    logic [eave_pkg::ANGLE_W-1:0]  prev_angle_reg, prev_angle_next;
    logic [eave_pkg::ERR_W-1:0]    err_cnt_reg, err_cnt_next;
    logic                          m_tvalid_reg, m_tvalid_next;

    logic [eave_pkg::FLAGS_W-1:0]  flags_reg, flags_next;
    logic                          neg_reg, neg_next;
    logic                          vel_ok_reg, vel_ok_next;
    logic [eave_pkg::ANGLE_W-1:0]  mag_reg, mag_next;
    logic [eave_pkg::ANGLE_W-1:0]  mplier_reg, mplier_next;
    logic [eave_pkg::ACC_W-1:0]    mcand_reg, mcand_next;
    logic [eave_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [eave_pkg::QUO_W-1:0]    rem_reg, rem_next;
    logic [eave_pkg::TIME_W-1:0]   dt_reg, dt_next;
    logic [eave_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [eave_pkg::POS_W-1:0]    pos_reg, pos_next;

    logic [eave_pkg::ANGLE_W-1:0]  out_raw_reg, out_raw_next;
    logic [eave_pkg::POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [eave_pkg::VEL_W-1:0]    out_vel_reg, out_vel_next;
    logic                          out_valid_reg, out_valid_next;
    logic [eave_pkg::FLAGS_W-1:0]  out_flags_reg, out_flags_next;
    logic [eave_pkg::ERR_W-1:0]    out_err_reg, out_err_next;
    logic [eave_pkg::TIME_W-1:0]   out_time_reg, out_time_next;

    // Input transaction fields.
    logic                          status_ok, angle_ok, s_accept;
    logic [7:0]                    in_status, in_high, in_low;
    logic [eave_pkg::TIME_W-1:0]   in_time;
    logic [eave_pkg::ANGLE_W-1:0]  in_raw;

    logic signed [eave_pkg::DIFF_W-1:0] diff, diff_wrap;
    logic [eave_pkg::DIFF_W-1:0]        diff_abs;
    logic [eave_pkg::TIME_W-1:0]        in_dt;

    // The shared adder.
    logic [eave_pkg::ACC_W-1:0]    add_a, add_b;
    logic                          add_cin;
    logic [eave_pkg::ACC_W:0]      add_sum;

    logic [eave_pkg::QUO_W-1:0]    quo;
    logic [eave_pkg::VEL_W-1:0]    vel_mag;
    logic                          out_free;

    assign status_ok = s_tuser[eave_pkg::S_USER_STATUS_OK];
    assign angle_ok  = s_tuser[eave_pkg::S_USER_ANGLE_OK];
    assign in_status = s_tdata[7:0];
    assign in_high   = s_tdata[15:8];
    assign in_low    = s_tdata[23:16];
    assign in_time   = s_tdata[87:24];
    assign in_raw    = {in_high[3:0], in_low};

    assign s_tready = (state_reg == eave_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Angle step wrapped into -2048..2048 counts, and the elapsed time.
    always_comb begin
        diff = $signed({2'b00, in_raw}) - $signed({2'b00, prev_angle_reg});
        if (diff < -14'sd2048) begin
            diff_wrap = diff + 14'sd4096;
        end else if (diff > 14'sd2048) begin
            diff_wrap = diff - 14'sd4096;
        end else begin
            diff_wrap = diff;
        end
        diff_abs = diff_wrap[eave_pkg::DIFF_W-1] ? 14'(-diff_wrap) : 14'(diff_wrap);
        in_dt    = in_time - prev_time_reg;
    end

    // Operand selection for the adder: multiply steps accumulate, division steps
    // subtract the time step from the shifted partial remainder.
    always_comb begin
        unique case (state_reg)
            eave_pkg::ST_MUL_POS, eave_pkg::ST_MUL_VEL: begin
                add_a   = acc_reg;
                add_b   = mplier_reg[0] ? mcand_reg : '0;
                add_cin = 1'b0;
            end
            eave_pkg::ST_DIV: begin
                add_a   = {25'd0, rem_reg, acc_reg[eave_pkg::QUO_W-1]};
                add_b   = ~dt_reg;
                add_cin = 1'b1;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b} + {{eave_pkg::ACC_W{1'b0}}, add_cin};
    end

    // Saturation of the quotient to the signed 32-bit range.
    always_comb begin
        quo = acc_reg[eave_pkg::QUO_W-1:0];
        if (neg_reg) begin
            vel_mag = (quo > eave_pkg::QUO_W'(eave_pkg::VEL_NEG_MAG)) ?
                      eave_pkg::VEL_NEG_MAG : quo[eave_pkg::VEL_W-1:0];
            vel_mag = eave_pkg::VEL_W'(0) - vel_mag;
        end else begin
            vel_mag = (quo > eave_pkg::QUO_W'(eave_pkg::VEL_POS_MAX)) ?
                      eave_pkg::VEL_POS_MAX : quo[eave_pkg::VEL_W-1:0];
        end
    end

    always_comb begin
        state_next      = state_reg;
        prev_time_next  = prev_time_reg;
        prev_angle_next = prev_angle_reg;
        err_cnt_next    = err_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        flags_next      = flags_reg;
        neg_next        = neg_reg;
        vel_ok_next     = vel_ok_reg;
        mag_next        = mag_reg;
        mplier_next     = mplier_reg;
        mcand_next      = mcand_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        dt_next         = dt_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        out_raw_next    = out_raw_reg;
        out_pos_next    = out_pos_reg;
        out_vel_next    = out_vel_reg;
        out_valid_next  = out_valid_reg;
        out_flags_next  = out_flags_reg;
        out_err_next    = out_err_reg;
        out_time_next   = out_time_reg;

        unique case (state_reg)
            eave_pkg::ST_IDLE: begin
                if (s_accept) begin
                    err_cnt_next = err_cnt_reg + eave_pkg::ERR_W'(!status_ok)
                                   + eave_pkg::ERR_W'(!angle_ok);
                    if (angle_ok) begin
                        prev_time_next  = in_time;
                        prev_angle_next = in_raw;
                        flags_next      = status_ok ?
                            in_status[eave_pkg::FLAG_LSB +: eave_pkg::FLAGS_W] : '0;
                        neg_next        = diff_wrap[eave_pkg::DIFF_W-1];
                        vel_ok_next     = (prev_time_reg != '0) && (in_dt != '0);
                        mag_next        = diff_abs[eave_pkg::ANGLE_W-1:0];
                        dt_next         = in_dt;
                        mplier_next     = in_raw;
                        mcand_next      = eave_pkg::PI_Q48;
                        acc_next        = eave_pkg::POS_ROUND;
                        cnt_next        = eave_pkg::CNT_W'(eave_pkg::MUL_STEPS - 1);
                        state_next      = eave_pkg::ST_MUL_POS;
                    end
                end
            end
            eave_pkg::ST_MUL_POS: begin
                acc_next    = add_sum[eave_pkg::ACC_W-1:0];
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - eave_pkg::CNT_W'(1);
                if (cnt_reg == '0) begin
                    pos_next    = add_sum[eave_pkg::POS_SHIFT +: eave_pkg::POS_W];
                    acc_next    = '0;
                    mcand_next  = eave_pkg::VEL_SCALE;
                    mplier_next = mag_reg;
                    cnt_next    = eave_pkg::CNT_W'(eave_pkg::MUL_STEPS - 1);
                    state_next  = eave_pkg::ST_MUL_VEL;
                end
            end
            eave_pkg::ST_MUL_VEL: begin
                acc_next    = add_sum[eave_pkg::ACC_W-1:0];
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - eave_pkg::CNT_W'(1);
                if (cnt_reg == '0) begin
                    // The dividend is the scaled step with its 25 fraction bits dropped.
                    acc_next   = eave_pkg::ACC_W'(add_sum[eave_pkg::VEL_SHIFT +: eave_pkg::QUO_W]);
                    rem_next   = '0;
                    cnt_next   = eave_pkg::CNT_W'(eave_pkg::DIV_STEPS - 1);
                    state_next = eave_pkg::ST_DIV;
                end
            end
            eave_pkg::ST_DIV: begin
                // A carry out means the shifted remainder was not below the time step.
                if (add_sum[eave_pkg::ACC_W]) begin
                    rem_next = add_sum[eave_pkg::QUO_W-1:0];
                end else begin
                    rem_next = {rem_reg[eave_pkg::QUO_W-2:0], acc_reg[eave_pkg::QUO_W-1]};
                end
                acc_next = eave_pkg::ACC_W'({acc_reg[eave_pkg::QUO_W-2:0],
                                             add_sum[eave_pkg::ACC_W]});
                cnt_next = cnt_reg - eave_pkg::CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = eave_pkg::ST_DONE;
                end
            end
            eave_pkg::ST_DONE: begin
                if (out_free) begin
                    out_raw_next   = prev_angle_reg;
                    out_pos_next   = pos_reg;
                    out_vel_next   = vel_ok_reg ? vel_mag : '0;
                    out_valid_next = vel_ok_reg;
                    out_flags_next = flags_reg;
                    out_err_next   = err_cnt_reg;
                    out_time_next  = prev_time_reg;
                    m_tvalid_next  = 1'b1;
                    state_next     = eave_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = eave_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eave_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg  <= '0;
            prev_angle_reg <= '0;
            err_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            prev_time_reg  <= prev_time_next;
            prev_angle_reg <= prev_angle_next;
            err_cnt_reg    <= err_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        flags_reg     <= flags_next;
        neg_reg       <= neg_next;
        vel_ok_reg    <= vel_ok_next;
        mag_reg       <= mag_next;
        mplier_reg    <= mplier_next;
        mcand_reg     <= mcand_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        dt_reg        <= dt_next;
        cnt_reg       <= cnt_next;
        pos_reg       <= pos_next;
        out_raw_reg   <= out_raw_next;
        out_pos_reg   <= out_pos_next;
        out_vel_reg   <= out_vel_next;
        out_valid_reg <= out_valid_next;
        out_flags_reg <= out_flags_next;
        out_err_reg   <= out_err_next;
        out_time_reg  <= out_time_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_time_reg, out_err_reg, out_flags_reg,
                       out_vel_reg, out_pos_reg, out_raw_reg};
    assign m_tuser[eave_pkg::M_USER_VEL_VALID] = out_valid_reg;

    `EAVE_ASSERT_NEXT(a_failed_angle_stays_idle, s_accept && !angle_ok,
                      state_reg == eave_pkg::ST_IDLE,
                      "a failed angle read started the sequencer")
    `EAVE_ASSERT_NEXT(a_good_angle_starts, s_accept && angle_ok,
                      state_reg == eave_pkg::ST_MUL_POS,
                      "a good sample did not start the position multiply")
    `EAVE_ASSERT_NEXT(a_done_loads_output, (state_reg == eave_pkg::ST_DONE) && out_free,
                      m_tvalid_reg && (state_reg == eave_pkg::ST_IDLE),
                      "finished result not handed to the output register")
    `EAVE_ASSERT_NOW(a_invalid_velocity_zero, m_tvalid_reg && !out_valid_reg,
                     out_vel_reg == '0,
                     "velocity not zero although marked invalid")

endmodule
